// ===== rtl/core/delta_bitpack_decoder_unit_defines.svh =====
// Assertion macros shared by the delta bit-pack decoder.
// Included by the top level; needs aclk and aresetn in scope.
`ifndef DELTA_BITPACK_DECODER_UNIT_DEFINES_SVH
`define DELTA_BITPACK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dbd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dbd next-cycle check failed");

`endif

// ===== rtl/core/dbd_pkg.sv =====
// Shared types, constants and helper functions for the delta bit-pack decoder.
// No dependencies; imported by the controller, datapath and top level.
package dbd_pkg;

    localparam int BYTE_W       = 8;
    localparam int LAST_BIT_IDX = 7;
    localparam int BIT_CNT_W    = 3;
    localparam int WIDTH_W      = 7;
    localparam int VALUE_W      = 64;
    localparam int PEND_W       = 63;
    localparam int PCNT_W       = 6;
    localparam int COUNT_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_VALUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_COUNT = 3'd4;

    localparam logic [WIDTH_W-1:0] DELTA_WIDTH_RST = 7'd8;
    localparam logic [WIDTH_W-1:0] VALUE_WIDTH_RST = 7'd64;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic restart;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic completes;
        logic run_done;
        logic last_bit;
        logic out_busy;
    } status_t;

    // Treat zero as one and anything above 64 as 64.
    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        if (w == '0) begin
            r = 7'd1;
        end else if (w > 7'd64) begin
            r = 7'd64;
        end else begin
            r = w;
        end
        return r;
    endfunction

    // Low-bit mask for a clamped width in 1..64.
    function automatic logic [VALUE_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [VALUE_W-1:0] m;
        if (w[6]) begin
            m = '1;
        end else begin
            m = (VALUE_W'(1) << w[5:0]) - VALUE_W'(1);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/dbd_ctrl.sv =====
// Controller for the delta bit-pack decoder: takes a word, then walks its bits.
// Depends on dbd_pkg for the state, command and status types.
module dbd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_start_run,
    output logic              s_ready,
    input  dbd_pkg::status_t  status,
    output dbd_pkg::cmd_t     cmd
);
    import dbd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   step_ok;

    // A bit may advance unless the run is done or it finishes a delta while the result is still held.
    assign step_ok = !status.run_done && !(status.completes && status.out_busy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (status.run_done) begin
                    state_next = ST_IDLE;
                end else if (step_ok && status.last_bit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.load_byte = 1'b0;
        cmd.restart   = 1'b0;
        cmd.step      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_byte = s_valid;
                cmd.restart   = s_valid && s_start_run;
            end
            ST_SHIFT: begin
                cmd.step = step_ok;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/dbd_datapath.sv =====
// Datapath for the delta bit-pack decoder: config registers, bit accumulator,
// running value adder and result register. Depends on dbd_pkg.
module dbd_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dbd_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic [dbd_pkg::BYTE_W-1:0]        s_data_byte,
    input  logic                              m_ready,
    input  dbd_pkg::cmd_t                     cmd,
    output dbd_pkg::status_t                  status,
    output logic                              m_valid,
    output logic [dbd_pkg::VALUE_W-1:0]       m_value,
    output logic                              m_last_value
);
    import dbd_pkg::*;

    logic [WIDTH_W-1:0]   delta_width_reg;
    logic                 signed_mode_reg;
    logic [WIDTH_W-1:0]   value_width_reg;
    logic [VALUE_W-1:0]   base_value_reg;
    logic [COUNT_W-1:0]   delta_count_reg;

    logic [VALUE_W-1:0]   running_reg;
    logic [PEND_W-1:0]    pending_reg;
    logic [PCNT_W-1:0]    pcount_reg;
    logic [COUNT_W-1:0]   done_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [VALUE_W-1:0]   m_value_reg;
    logic                 m_last_reg;

    logic [WIDTH_W-1:0]   dw;
    logic [WIDTH_W-1:0]   vw;
    logic [VALUE_W-1:0]   dmask;
    logic [VALUE_W-1:0]   vmask;
    logic [VALUE_W-1:0]   acc;
    logic [WIDTH_W-1:0]   cnt;
    logic [PCNT_W-1:0]    top_idx;
    logic [VALUE_W-1:0]   d;
    logic [VALUE_W-1:0]   d_ext;
    logic [VALUE_W-1:0]   sum;
    logic [COUNT_W-1:0]   done_inc;

    assign dw       = clamp_width(delta_width_reg);
    assign vw       = clamp_width(value_width_reg);
    assign dmask    = width_mask(dw);
    assign vmask    = width_mask(vw);
    assign acc      = {pending_reg, byte_reg[LAST_BIT_IDX]};
    assign cnt      = {1'b0, pcount_reg} + WIDTH_W'(1);
    assign top_idx  = PCNT_W'(dw - WIDTH_W'(1));
    assign d        = acc & dmask;
    // Negative deltas: sign-extend so a plain add does the subtraction.
    assign d_ext    = (signed_mode_reg && acc[top_idx]) ? (d | ~dmask) : d;
    assign sum      = ((running_reg & vmask) + d_ext) & vmask;
    assign done_inc = done_reg + COUNT_W'(1);

    assign status.completes = (cnt >= dw);
    assign status.run_done  = (done_reg >= delta_count_reg);
    assign status.last_bit  = (bit_cnt_reg == BIT_CNT_W'(LAST_BIT_IDX));
    assign status.out_busy  = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_width_reg <= DELTA_WIDTH_RST;
            signed_mode_reg <= 1'b0;
            value_width_reg <= VALUE_WIDTH_RST;
            base_value_reg  <= '0;
            delta_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DELTA_WIDTH: delta_width_reg <= cfg_wr_data[WIDTH_W-1:0];
                CFG_SIGNED_MODE: signed_mode_reg <= cfg_wr_data[0];
                CFG_VALUE_WIDTH: value_width_reg <= cfg_wr_data[WIDTH_W-1:0];
                CFG_BASE_VALUE:  base_value_reg  <= cfg_wr_data;
                CFG_DELTA_COUNT: delta_count_reg <= cfg_wr_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= '0;
            pending_reg <= '0;
            pcount_reg  <= '0;
            done_reg    <= '0;
            bit_cnt_reg <= '0;
        end else if (cmd.load_byte) begin
            bit_cnt_reg <= '0;
            if (cmd.restart) begin
                running_reg <= base_value_reg & vmask;
                pending_reg <= '0;
                pcount_reg  <= '0;
                done_reg    <= '0;
            end
        end else if (cmd.step) begin
            bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
            if (status.completes) begin
                running_reg <= sum;
                pending_reg <= '0;
                pcount_reg  <= '0;
                done_reg    <= done_inc;
            end else begin
                pending_reg <= acc[PEND_W-1:0];
                pcount_reg  <= cnt[PCNT_W-1:0];
            end
        end
    end

    // Byte shifter: MSB sits at the top and is consumed first.
    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            byte_reg <= s_data_byte;
        end else if (cmd.step) begin
            byte_reg <= {byte_reg[BYTE_W-2:0], 1'b0};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.step && status.completes) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && status.completes) begin
            m_value_reg <= sum;
            m_last_reg  <= (done_inc == delta_count_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_last_value = m_last_reg;

endmodule

// ===== rtl/core/delta_bitpack_decoder_unit.sv =====
// Delta bit-pack decoder: one word is taken in a cycle of its own, then its bits are
// walked MSB first at one bit per cycle while no completing bit waits on the result; the
// next word is taken after the last bit, or straight away when the run is complete;
// the bit-serial accumulator sets the rate. A finished delta shows on the result port in
// the cycle after its last bit; a completing bit waits while the result register is held.
// Reset (aresetn low, synchronous) restores defaults, clears all but byte and result data.
module delta_bitpack_decoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dbd_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dbd_pkg::BYTE_W-1:0]        s_data_byte,
    input  logic                              s_start_run,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dbd_pkg::VALUE_W-1:0]       m_value,
    output logic                              m_last_value
);
    import dbd_pkg::*;

    cmd_t    cmd;
    status_t status;

    dbd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_start_run (s_start_run),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    dbd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_data_byte  (s_data_byte),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_value      (m_value),
        .m_last_value (m_last_value)
    );

`include "delta_bitpack_decoder_unit_defines.svh"

    `DBD_ASSERT_NEXT(a_emit_on_complete, cmd.step && status.completes, m_valid)
    `DBD_ASSERT_NOW(a_no_step_when_done, status.run_done, !cmd.step)
    `DBD_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

endmodule

// ===== tb/sv/tb_delta_bitpack_decoder_unit.sv =====
// Self-checking testbench for delta_bitpack_decoder_unit: random valid/ready traffic
// on both channels, checked against an in-bench decoder of the packed delta stream.
// Depends on dbd_pkg and the delta_bitpack_decoder_unit RTL.
module tb_delta_bitpack_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } word_t;

    typedef struct packed {
        logic [63:0] value;
        logic        last;
    } decoded_t;

    logic                            aclk;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [dbd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [dbd_pkg::CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [dbd_pkg::BYTE_W-1:0]      s_data_byte = '0;
    logic                            s_start_run = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [dbd_pkg::VALUE_W-1:0]     m_value;
    logic                            m_last_value;

    // Register copies seen by the decoder below
    logic [6:0]  cfg_dw = dbd_pkg::DELTA_WIDTH_RST;
    logic        cfg_sgn = 1'b0;
    logic [6:0]  cfg_vw = dbd_pkg::VALUE_WIDTH_RST;
    logic [63:0] cfg_base = '0;
    logic [15:0] cfg_cnt = '0;

    // Decoder state
    logic [63:0] run_val = '0;
    logic [62:0] pend_bits = '0;
    logic [5:0]  pend_cnt = '0;
    logic [15:0] done_cnt = '0;

    word_t    word_q[$];
    decoded_t decoded_q[$];
    word_t    cur_word;
    decoded_t want;
    bit       calm = 1'b0;
    int       mismatches = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    int       quiet_cycles = 0;

    delta_bitpack_decoder_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_start_run  (s_start_run),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_last_value (m_last_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Shift one word through the delta accumulator, MSB first, and queue every value.
    function automatic void decode_word(input logic [7:0] data, input logic restart);
        int unsigned dw;
        int unsigned vw;
        int unsigned cnt;
        logic [63:0] dmask;
        logic [63:0] vmask;
        logic [63:0] acc;
        logic [63:0] d;
        logic [63:0] v;
        decoded_t    res;
        dw = (cfg_dw == 7'd0) ? 1 : (cfg_dw > 7'd64) ? 64 : cfg_dw;
        vw = (cfg_vw == 7'd0) ? 1 : (cfg_vw > 7'd64) ? 64 : cfg_vw;
        dmask = (dw == 64) ? {64{1'b1}} : (64'd1 << dw) - 64'd1;
        vmask = (vw == 64) ? {64{1'b1}} : (64'd1 << vw) - 64'd1;
        if (restart) begin
            run_val = cfg_base & vmask;
            pend_bits = '0;
            pend_cnt = '0;
            done_cnt = '0;
        end
        for (int b = 7; b >= 0; b--) begin
            // drop everything once the run is complete
            if (done_cnt >= cfg_cnt) break;
            acc = {pend_bits, data[b]};
            cnt = pend_cnt + 1;
            if (cnt >= dw) begin
                d = acc & dmask;
                v = run_val & vmask;
                if (cfg_sgn && d[dw-1]) begin
                    v = (v - ((~d & dmask) + 64'd1)) & vmask;
                end else begin
                    v = (v + d) & vmask;
                end
                run_val = v;
                pend_bits = '0;
                pend_cnt = '0;
                done_cnt = done_cnt + 16'd1;
                res.value = v;
                res.last = (done_cnt == cfg_cnt);
                decoded_q = {decoded_q, res};
            end else begin
                pend_bits = acc[62:0];
                pend_cnt = 6'(cnt);
            end
        end
    endfunction

    // Call at a rising edge with the block idle.
    task automatic write_reg(input logic [dbd_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            dbd_pkg::CFG_DELTA_WIDTH: cfg_dw = val[6:0];
            dbd_pkg::CFG_SIGNED_MODE: cfg_sgn = val[0];
            dbd_pkg::CFG_VALUE_WIDTH: cfg_vw = val[6:0];
            dbd_pkg::CFG_BASE_VALUE:  cfg_base = val;
            dbd_pkg::CFG_DELTA_COUNT: cfg_cnt = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_run(input logic [6:0] dw, input logic sgn, input logic [6:0] vw,
                           input logic [63:0] base, input logic [15:0] cnt);
        write_reg(dbd_pkg::CFG_DELTA_WIDTH, 64'(dw));
        write_reg(dbd_pkg::CFG_SIGNED_MODE, 64'(sgn));
        write_reg(dbd_pkg::CFG_VALUE_WIDTH, 64'(vw));
        write_reg(dbd_pkg::CFG_BASE_VALUE, base);
        write_reg(dbd_pkg::CFG_DELTA_COUNT, 64'(cnt));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_word(input logic [7:0] data, input logic restart);
        word_t w;
        w.data = data;
        w.restart = restart;
        word_q = {word_q, w};
    endtask

    // Hold until every word is taken and every value is out, then let the
    // bit walker finish any padding.
    task automatic wait_drained();
        do @(negedge aclk);
        while (word_q.size() != 0 || s_valid || decoded_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int          sent;
        int          nwords;
        int          eff_dw;
        int          r;
        logic [6:0]  dw;
        logic [6:0]  vw;
        logic [63:0] base;
        logic [15:0] cnt;
        sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // run length is zero out of reset: nothing comes back
        queue_word(8'hFF, 1'b1);
        queue_word(8'h00, 1'b0);
        wait_drained();

        // one-bit deltas into a one-bit value, then padding and a word past the run
        set_run(7'd1, 1'b0, 7'd1, {64{1'b1}}, 16'd10);
        queue_word(8'hFF, 1'b1);
        queue_word(8'h80, 1'b0);
        queue_word(8'hA5, 1'b0);
        wait_drained();

        // full-width signed delta: most negative value subtracted from all ones
        set_run(7'd64, 1'b1, 7'd64, {64{1'b1}}, 16'd1);
        queue_word(8'h80, 1'b1);
        repeat (7) queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b0);
        wait_drained();

        // signed 3-bit deltas with a restart that discards pending bits
        set_run(7'd3, 1'b1, 7'd7, 64'd5, 16'd5);
        queue_word(8'hEE, 1'b1);
        queue_word(8'h5A, 1'b1);
        queue_word(8'hFF, 1'b0);
        wait_drained();

        // unsigned wrap at 8 bits
        set_run(7'd8, 1'b0, 7'd8, 64'hFFFF_FFFF_FFFF_FFF0, 16'd3);
        queue_word(8'h20, 1'b1);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b0);
        wait_drained();

        // zero delta width acts as one, oversized value width as 64, longest run
        set_run(7'd0, 1'b1, 7'd127, 64'd0, 16'hFFFF);
        queue_word(8'hF0, 1'b1);
        wait_drained();

        for (int phase = 0; sent < RANDOM_WORDS; phase++) begin
            calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 60) dw = 7'($urandom_range(1, 12));
            else if (r < 85) dw = 7'($urandom_range(13, 64));
            else if (r < 92) dw = 7'd0;
            else dw = 7'($urandom_range(65, 127));
            r = $urandom_range(0, 99);
            if (r < 50) vw = 7'($urandom_range(1, 64));
            else if (r < 80) vw = 7'd64;
            else if (r < 90) vw = 7'd0;
            else vw = 7'($urandom_range(65, 127));
            r = $urandom_range(0, 9);
            base = (r == 0) ? 64'd0 : (r == 1) ? {64{1'b1}} : {$urandom, $urandom};
            eff_dw = (dw == 7'd0) ? 1 : (dw > 7'd64) ? 64 : dw;
            nwords = $urandom_range(4, 20);
            r = $urandom_range(0, 99);
            if (r < 70) cnt = 16'($urandom_range(1, nwords * 8 / eff_dw + 1));
            else if (r < 80) cnt = 16'd0;
            else if (r < 90) cnt = 16'hFFFF;
            else cnt = 16'($urandom_range(0, 65535));
            set_run(dw, 1'($urandom_range(0, 1)), vw, base, cnt);
            for (int k = 0; k < nwords; k++) begin
                queue_word(8'($urandom_range(0, 255)),
                           (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0));
                // once, let the result side run dry in the middle of a run
                if (phase == 1 && k == nwords / 2) wait_drained();
            end
            sent += nwords;
            wait_drained();
        end

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Word driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                decode_word(s_data_byte, s_start_run);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap--;
                end else if (word_q.size() != 0) begin
                    cur_word = word_q.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= cur_word.data;
                    s_start_run <= cur_word.restart;
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Value monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word: value %h last %b", m_value, m_last_value);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (m_value !== want.value || m_last_value !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected value %h last %b, got value %h last %b",
                                     want.value, want.last, m_value, m_last_value);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dbd_pkg.sv
rtl/core/dbd_ctrl.sv
rtl/core/dbd_datapath.sv
rtl/core/delta_bitpack_decoder_unit.sv
tb/sv/tb_delta_bitpack_decoder_unit.sv
